/* rtl/core/lprf_pkg.sv */
// Package for the length-prefixed record FIFO.
// Holds the store sizing, command/status codes and the controller-datapath interface types.
`timescale 1ns / 1ps

package lprf_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int SIZE_W      = PTR_W + 1;
    localparam int CFG_W       = 13;
    localparam int CNT_W       = 13;
    localparam int BYTE_W      = 8;

    typedef enum logic [1:0] {
        CMD_BEGIN_PUT = 2'd0,
        CMD_PUT_BYTE  = 2'd1,
        CMD_GET       = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SEQ   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_BEGIN_PUT,
        OP_PUT_BYTE,
        OP_CLEAR,
        OP_REJ_SEQ,
        OP_REJ_FULL,
        OP_REJ_EMPTY,
        OP_RD_LEN,
        OP_RD_DATA,
        OP_LEN_TAKE,
        OP_LEN_ZERO,
        OP_DATA_TAKE
    } t_op;

    typedef struct packed {
        t_cmd cmd;
        logic put_open;
        logic get_open;
        logic count_nz;
        logic fits;
        logic q_zero;
    } t_dp_status;

endpackage

/* rtl/core/lprf_ctrl.sv */
// Controller state machine for the length-prefixed record FIFO.
// Sequences each transaction and drives datapath operations; uses lprf_pkg.
`timescale 1ns / 1ps

module lprf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  lprf_pkg::t_dp_status  i_st,
    output lprf_pkg::t_op         o_op,
    output logic                  o_done
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LEN  = 4'b0100,
        S_DATA = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    lprf_pkg::t_op op;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        op      = lprf_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    op      = lprf_pkg::OP_LATCH;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                unique case (i_st.cmd)
                    lprf_pkg::CMD_BEGIN_PUT: begin
                        if (i_st.put_open) begin
                            op = lprf_pkg::OP_REJ_SEQ;
                        end else if (!i_st.fits) begin
                            op = lprf_pkg::OP_REJ_FULL;
                        end else begin
                            op = lprf_pkg::OP_BEGIN_PUT;
                        end
                    end
                    lprf_pkg::CMD_PUT_BYTE: begin
                        op = i_st.put_open ? lprf_pkg::OP_PUT_BYTE : lprf_pkg::OP_REJ_SEQ;
                    end
                    lprf_pkg::CMD_GET: begin
                        if (i_st.get_open) begin
                            op      = lprf_pkg::OP_RD_DATA;
                            n_state = S_DATA;
                            n_done  = 1'b0;
                        end else if (i_st.count_nz) begin
                            op      = lprf_pkg::OP_RD_LEN;
                            n_state = S_LEN;
                            n_done  = 1'b0;
                        end else begin
                            op = lprf_pkg::OP_REJ_EMPTY;
                        end
                    end
                    lprf_pkg::CMD_CLEAR: begin
                        op = lprf_pkg::OP_CLEAR;
                    end
                    default: begin
                        op = lprf_pkg::OP_CLEAR;
                    end
                endcase
            end
            S_LEN: begin
                if (i_st.q_zero) begin
                    op      = lprf_pkg::OP_LEN_ZERO;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    op      = lprf_pkg::OP_LEN_TAKE;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                op      = lprf_pkg::OP_DATA_TAKE;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_op   = op;
    assign o_done = r_done;

endmodule

/* rtl/core/lprf_dpath.sv */
// Datapath for the length-prefixed record FIFO: byte store, pointers, counters, result registers.
// Executes operations from lprf_ctrl; uses lprf_pkg.
`timescale 1ns / 1ps

module lprf_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [lprf_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic [1:0]                            i_cmd,
    input  logic [lprf_pkg::BYTE_W-1:0]           i_record_length,
    input  logic [lprf_pkg::BYTE_W-1:0]           i_data_byte,
    input  lprf_pkg::t_op                         i_op,
    output lprf_pkg::t_dp_status                  o_st,
    output logic [1:0]                            o_status,
    output logic [lprf_pkg::BYTE_W-1:0]           o_read_byte,
    output logic [lprf_pkg::BYTE_W-1:0]           o_record_len,
    output logic                                  o_last_byte,
    output logic [lprf_pkg::CNT_W-1:0]            o_records_stored,
    output logic [lprf_pkg::CFG_W-1:0]            o_free_space
);

    localparam int PW = lprf_pkg::PTR_W;
    localparam int SW = lprf_pkg::SIZE_W;
    localparam int BW = lprf_pkg::BYTE_W;
    localparam int CW = lprf_pkg::CNT_W;

    logic [BW-1:0]  r_mem [lprf_pkg::STORE_DEPTH];
    logic [BW-1:0]  r_q;

    logic [SW-1:0]  r_ring;
    logic [PW-1:0]  r_rp, r_wp;
    logic [CW-1:0]  r_count;
    logic           r_put_open, r_get_open;
    logic [BW-1:0]  r_put_rem, r_get_rem, r_get_len;

    lprf_pkg::t_cmd r_cmd;
    logic [BW-1:0]  r_rlen, r_dbyte;

    lprf_pkg::t_status r_status;
    logic [BW-1:0]  r_rbyte, r_olen;
    logic           r_last;

    logic [SW-1:0]  cfg_sat;
    logic [SW-1:0]  free;
    logic [PW-1:0]  rp_adv, wp_adv;
    logic [PW-1:0]  mem_addr;
    logic           mem_we, mem_re;
    logic [BW-1:0]  mem_wdata;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [SW-1:0] s);
        logic [SW-1:0] n;
        n = {1'b0, p} + SW'(1);
        return (n >= s) ? '0 : n[PW-1:0];
    endfunction

    assign rp_adv = advance(r_rp, r_ring);
    assign wp_adv = advance(r_wp, r_ring);

    always_comb begin
        if (r_wp > r_rp) begin
            free = r_ring - ({1'b0, r_wp} - {1'b0, r_rp});
        end else if (r_wp < r_rp) begin
            free = {1'b0, r_rp} - {1'b0, r_wp};
        end else begin
            free = ((r_count != '0) || r_put_open) ? '0 : r_ring;
        end
    end

    always_comb begin
        if (i_cfg_wdata < lprf_pkg::CFG_W'(2)) begin
            cfg_sat = SW'(2);
        end else if (32'(i_cfg_wdata) > 32'(lprf_pkg::STORE_DEPTH)) begin
            cfg_sat = SW'(lprf_pkg::STORE_DEPTH);
        end else begin
            cfg_sat = SW'(i_cfg_wdata);
        end
    end

    always_comb begin
        mem_addr  = r_rp;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = r_dbyte;
        unique case (i_op)
            lprf_pkg::OP_BEGIN_PUT: begin
                mem_addr  = r_wp;
                mem_we    = 1'b1;
                mem_wdata = r_rlen;
            end
            lprf_pkg::OP_PUT_BYTE: begin
                mem_addr  = r_wp;
                mem_we    = 1'b1;
            end
            lprf_pkg::OP_RD_LEN, lprf_pkg::OP_RD_DATA: begin
                mem_re    = 1'b1;
            end
            lprf_pkg::OP_LEN_TAKE: begin
                mem_addr  = rp_adv;
                mem_re    = 1'b1;
            end
            default: begin
                mem_re    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_q <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == lprf_pkg::OP_LATCH) begin
            r_cmd   <= lprf_pkg::t_cmd'(i_cmd);
            r_rlen  <= i_record_length;
            r_dbyte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring     <= SW'(lprf_pkg::STORE_DEPTH);
            r_rp       <= '0;
            r_wp       <= '0;
            r_count    <= '0;
            r_put_open <= 1'b0;
            r_put_rem  <= '0;
            r_get_open <= 1'b0;
            r_get_rem  <= '0;
            r_get_len  <= '0;
            r_status   <= lprf_pkg::ST_OK;
            r_rbyte    <= '0;
            r_olen     <= '0;
            r_last     <= 1'b0;
        end else if (i_cfg_we) begin
            r_ring     <= cfg_sat;
            r_rp       <= '0;
            r_wp       <= '0;
            r_count    <= '0;
            r_put_open <= 1'b0;
            r_put_rem  <= '0;
            r_get_open <= 1'b0;
            r_get_rem  <= '0;
            r_get_len  <= '0;
        end else begin
            unique case (i_op)
                lprf_pkg::OP_BEGIN_PUT: begin
                    r_wp <= wp_adv;
                    if (r_rlen == '0) begin
                        r_count <= r_count + CW'(1);
                    end else begin
                        r_put_open <= 1'b1;
                        r_put_rem  <= r_rlen;
                    end
                    r_status <= lprf_pkg::ST_OK;
                    r_rbyte  <= '0;
                    r_olen   <= '0;
                    r_last   <= 1'b0;
                end
                lprf_pkg::OP_PUT_BYTE: begin
                    r_wp      <= wp_adv;
                    r_put_rem <= r_put_rem - BW'(1);
                    if (r_put_rem == BW'(1)) begin
                        r_put_open <= 1'b0;
                        r_count    <= r_count + CW'(1);
                    end
                    r_status <= lprf_pkg::ST_OK;
                    r_rbyte  <= '0;
                    r_olen   <= '0;
                    r_last   <= 1'b0;
                end
                lprf_pkg::OP_CLEAR: begin
                    r_rp       <= '0;
                    r_wp       <= '0;
                    r_count    <= '0;
                    r_put_open <= 1'b0;
                    r_put_rem  <= '0;
                    r_get_open <= 1'b0;
                    r_get_rem  <= '0;
                    r_get_len  <= '0;
                    r_status   <= lprf_pkg::ST_OK;
                    r_rbyte    <= '0;
                    r_olen     <= '0;
                    r_last     <= 1'b0;
                end
                lprf_pkg::OP_REJ_SEQ, lprf_pkg::OP_REJ_FULL, lprf_pkg::OP_REJ_EMPTY: begin
                    priority case (i_op)
                        lprf_pkg::OP_REJ_SEQ:  r_status <= lprf_pkg::ST_SEQ;
                        lprf_pkg::OP_REJ_FULL: r_status <= lprf_pkg::ST_FULL;
                        default:               r_status <= lprf_pkg::ST_EMPTY;
                    endcase
                    r_rbyte <= '0;
                    r_olen  <= '0;
                    r_last  <= 1'b0;
                end
                lprf_pkg::OP_LEN_TAKE: begin
                    r_get_len  <= r_q;
                    r_get_rem  <= r_q;
                    r_get_open <= 1'b1;
                    r_rp       <= rp_adv;
                end
                lprf_pkg::OP_LEN_ZERO: begin
                    r_get_len <= '0;
                    r_get_rem <= '0;
                    r_rp      <= rp_adv;
                    if (r_count != '0) begin
                        r_count <= r_count - CW'(1);
                    end
                    r_status <= lprf_pkg::ST_OK;
                    r_rbyte  <= '0;
                    r_olen   <= '0;
                    r_last   <= 1'b1;
                end
                lprf_pkg::OP_DATA_TAKE: begin
                    r_rp      <= rp_adv;
                    r_get_rem <= r_get_rem - BW'(1);
                    r_status  <= lprf_pkg::ST_OK;
                    r_rbyte   <= r_q;
                    r_olen    <= r_get_len;
                    if (r_get_rem == BW'(1)) begin
                        r_get_open <= 1'b0;
                        r_last     <= 1'b1;
                        if (r_count != '0) begin
                            r_count <= r_count - CW'(1);
                        end
                    end else begin
                        r_last <= 1'b0;
                    end
                end
                default: begin
                    r_last <= r_last;
                end
            endcase
        end
    end

    always_comb begin
        o_st.cmd      = r_cmd;
        o_st.put_open = r_put_open;
        o_st.get_open = r_get_open;
        o_st.count_nz = (r_count != '0);
        o_st.fits     = ((SW'(r_rlen) + SW'(1)) <= free);
        o_st.q_zero   = (r_q == '0);
    end

    assign o_status         = r_status;
    assign o_read_byte      = r_rbyte;
    assign o_record_len     = r_olen;
    assign o_last_byte      = r_last;
    assign o_records_stored = r_count;
    assign o_free_space     = lprf_pkg::CFG_W'(free);

endmodule

/* rtl/core/length_prefixed_record_fifo.sv */
// Length-prefixed record FIFO: a circular byte store of variable-length records.
// Puts, clear and rejects finish in the execute state; a get reads the data byte inside a
// record and, at a record's start, the length byte and then, unless it is zero, the data byte.
// The result strobe is registered. A new transaction is taken in the strobe cycle, so one is
// handled at a time on the single-port byte store with registered read. Synchronous
// active-low reset empties the buffer and sets the size to the full store; contents are kept.
`timescale 1ns / 1ps

module length_prefixed_record_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lprf_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_cmd,
    input  logic [lprf_pkg::BYTE_W-1:0]      i_record_length,
    input  logic [lprf_pkg::BYTE_W-1:0]      i_data_byte,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [lprf_pkg::BYTE_W-1:0]      o_read_byte,
    output logic [lprf_pkg::BYTE_W-1:0]      o_record_len,
    output logic                             o_last_byte,
    output logic [lprf_pkg::CNT_W-1:0]       o_records_stored,
    output logic [lprf_pkg::CFG_W-1:0]       o_free_space
);

    lprf_pkg::t_op        op;
    lprf_pkg::t_dp_status st;

    lprf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_st    (st),
        .o_op    (op),
        .o_done  (o_done)
    );

    lprf_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (i_cmd),
        .i_record_length  (i_record_length),
        .i_data_byte      (i_data_byte),
        .i_op             (op),
        .o_st             (st),
        .o_status         (o_status),
        .o_read_byte      (o_read_byte),
        .o_record_len     (o_record_len),
        .o_last_byte      (o_last_byte),
        .o_records_stored (o_records_stored),
        .o_free_space     (o_free_space)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for length_prefixed_record_fifo.
// Holds the record FIFO scoreboard class and the top module tb. It runs directed and random
// transactions across several ring sizes and depends on lprf_pkg and the DUT only.
`timescale 1ns / 1ps

import lprf_pkg::*;

class record_fifo_scoreboard;
    typedef struct {
        t_status            status;
        logic [BYTE_W-1:0]  rd_byte;
        logic [BYTE_W-1:0]  rec_len;
        logic               last;
        logic [CNT_W-1:0]   stored;
        logic [CFG_W-1:0]   free;
    } fifo_result_t;

    bit [BYTE_W-1:0] ring_mem [STORE_DEPTH];
    int unsigned     size_reg;
    int unsigned     rd_ptr;
    int unsigned     wr_ptr;
    int unsigned     rec_count;
    bit              put_active;
    int unsigned     put_left;
    bit              get_active;
    int unsigned     get_left;
    int unsigned     get_len;
    int unsigned     errors;
    fifo_result_t    expected_q [$];

    function new();
        size_reg = STORE_DEPTH;
        errors   = 0;
        clear_ring();
    endfunction

    function void clear_ring();
        rd_ptr     = 0;
        wr_ptr     = 0;
        rec_count  = 0;
        put_active = 1'b0;
        put_left   = 0;
        get_active = 1'b0;
        get_left   = 0;
        get_len    = 0;
    endfunction

    function void set_size(input logic [CFG_W-1:0] value);
        size_reg = 32'(value);
        clear_ring();
    endfunction

    function int unsigned ring_size();
        if (size_reg < 2) return 2;
        if (size_reg > STORE_DEPTH) return STORE_DEPTH;
        return size_reg;
    endfunction

    function int unsigned advance(input int unsigned ptr);
        return (ptr + 1 >= ring_size()) ? 0 : ptr + 1;
    endfunction

    // equal pointers mean full while a record is held or a put is open
    function int unsigned free_bytes();
        int unsigned used;
        if (wr_ptr > rd_ptr) used = wr_ptr - rd_ptr;
        else if (wr_ptr < rd_ptr) used = ring_size() - (rd_ptr - wr_ptr);
        else used = (rec_count > 0 || put_active) ? ring_size() : 0;
        return (used > ring_size()) ? 0 : ring_size() - used;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void note_input(input t_cmd cmd, input logic [BYTE_W-1:0] rlen,
                             input logic [BYTE_W-1:0] dbyte);
        fifo_result_t r;
        bit           have;
        r.status  = ST_OK;
        r.rd_byte = '0;
        r.rec_len = '0;
        r.last    = 1'b0;
        case (cmd)
            CMD_BEGIN_PUT: begin
                if (put_active) begin
                    r.status = ST_SEQ;
                end else if (int'(rlen) + 1 > free_bytes()) begin
                    r.status = ST_FULL;
                end else begin
                    ring_mem[PTR_W'(wr_ptr)] = rlen;
                    wr_ptr = advance(wr_ptr);
                    if (rlen == 0) begin
                        rec_count++;
                    end else begin
                        put_active = 1'b1;
                        put_left   = 32'(rlen);
                    end
                end
            end
            CMD_PUT_BYTE: begin
                if (!put_active) begin
                    r.status = ST_SEQ;
                end else begin
                    ring_mem[PTR_W'(wr_ptr)] = dbyte;
                    wr_ptr = advance(wr_ptr);
                    put_left--;
                    if (put_left == 0) begin
                        put_active = 1'b0;
                        rec_count++;
                    end
                end
            end
            CMD_GET: begin
                have = get_active;
                if (!have && rec_count > 0) begin
                    get_len    = 32'(ring_mem[PTR_W'(rd_ptr)]);
                    rd_ptr     = advance(rd_ptr);
                    get_left   = get_len;
                    get_active = 1'b1;
                    have       = 1'b1;
                end
                if (!have) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.rec_len = BYTE_W'(get_len);
                    if (get_left != 0) begin
                        r.rd_byte = ring_mem[PTR_W'(rd_ptr)];
                        rd_ptr = advance(rd_ptr);
                        get_left--;
                    end
                    if (get_left == 0) begin
                        r.last     = 1'b1;
                        get_active = 1'b0;
                        if (rec_count > 0) rec_count--;
                    end
                end
            end
            default: begin
                clear_ring();
            end
        endcase
        r.stored = CNT_W'(rec_count);
        r.free   = CFG_W'(free_bytes());
        expected_q.push_back(r);
    endfunction

    task report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(input logic [1:0] status, input logic [BYTE_W-1:0] rd_byte,
                      input logic [BYTE_W-1:0] rec_len, input logic last,
                      input logic [CNT_W-1:0] stored, input logic [CFG_W-1:0] free);
        fifo_result_t e;
        if (expected_q.size() == 0) begin
            report_mismatch("result strobe with no transaction outstanding");
            return;
        end
        e = expected_q.pop_front();
        compare_field("status", 32'(status), 32'(e.status));
        compare_field("read_byte", 32'(rd_byte), 32'(e.rd_byte));
        compare_field("record_len", 32'(rec_len), 32'(e.rec_len));
        compare_field("last_byte", 32'(last), 32'(e.last));
        compare_field("records_stored", 32'(stored), 32'(e.stored));
        compare_field("free_space", 32'(free), 32'(e.free));
    endtask
endclass

module tb;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 130;
    localparam int PHASE_COUNT  = 11;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               start;
    logic               busy;
    logic [1:0]         i_cmd;
    logic [BYTE_W-1:0]  i_record_length;
    logic [BYTE_W-1:0]  i_data_byte;
    logic               o_done;
    logic [1:0]         o_status;
    logic [BYTE_W-1:0]  o_read_byte;
    logic [BYTE_W-1:0]  o_record_len;
    logic               o_last_byte;
    logic [CNT_W-1:0]   o_records_stored;
    logic [CFG_W-1:0]   o_free_space;

    record_fifo_scoreboard sb;
    int                    cycle_count = 0;
    int                    items_sent  = 0;
    bit                    no_idle     = 1'b0;

    length_prefixed_record_fifo u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_record_length  (i_record_length),
        .i_data_byte      (i_data_byte),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_read_byte      (o_read_byte),
        .o_record_len     (o_record_len),
        .o_last_byte      (o_last_byte),
        .o_records_stored (o_records_stored),
        .o_free_space     (o_free_space)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_status, o_read_byte, o_record_len, o_last_byte,
                            o_records_stored, o_free_space);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return BYTE_W'($urandom_range(0, 7));
        if (roll < 92) return BYTE_W'($urandom_range(0, 40));
        if (roll < 97) return BYTE_W'($urandom_range(0, 255));
        return 8'd255;
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [BYTE_W-1:0] rlen,
                             input logic [BYTE_W-1:0] dbyte);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_record_length <= rlen;
        i_data_byte     <= dbyte;
        do @(posedge i_clk); while (busy);
        sb.note_input(cmd, rlen, dbyte);
        items_sent++;
    endtask

    task automatic idle_drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] value);
        idle_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_size(value);
        i_cfg_we <= 1'b0;
    endtask

    // broken records may stop short, leaving the put open for a later begin put to hit
    task automatic put_record(input logic [BYTE_W-1:0] len, input bit broken);
        int n;
        send_item(CMD_BEGIN_PUT, len, BYTE_W'($urandom));
        n = broken ? int'($urandom_range(0, 32'(len))) : int'(len);
        repeat (n) send_item(CMD_PUT_BYTE, BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic run_phase(input int budget);
        int stop_at;
        int roll;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                put_record(pick_len(), $urandom_range(0, 99) < 8);
            else if (roll < 85)
                repeat ($urandom_range(1, 12))
                    send_item(CMD_GET, BYTE_W'($urandom), BYTE_W'($urandom));
            else if (roll < 89)
                send_item(CMD_CLEAR, BYTE_W'($urandom), BYTE_W'($urandom));
            else
                send_item(t_cmd'($urandom_range(0, 3)), BYTE_W'($urandom),
                          BYTE_W'($urandom));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] sizes [PHASE_COUNT];
        sb = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        start           <= 1'b0;
        i_cmd           <= CMD_GET;
        i_record_length <= '0;
        i_data_byte     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(CMD_GET, 8'h00, 8'h00);
        send_item(CMD_PUT_BYTE, 8'h00, 8'hFF);
        send_item(CMD_BEGIN_PUT, 8'd0, 8'h00);
        send_item(CMD_GET, 8'h00, 8'h00);
        send_item(CMD_BEGIN_PUT, 8'd2, 8'h00);
        send_item(CMD_BEGIN_PUT, 8'd5, 8'h00);
        send_item(CMD_GET, 8'hFF, 8'hFF);
        send_item(CMD_PUT_BYTE, 8'hFF, 8'hFF);
        send_item(CMD_PUT_BYTE, 8'h00, 8'h00);
        send_item(CMD_BEGIN_PUT, 8'd1, 8'hA5);
        send_item(CMD_GET, 8'h00, 8'h00);
        send_item(CMD_PUT_BYTE, 8'h00, 8'h5A);
        send_item(CMD_GET, 8'h00, 8'h00);
        send_item(CMD_GET, 8'h00, 8'h00);
        send_item(CMD_GET, 8'h00, 8'h00);
        send_item(CMD_BEGIN_PUT, 8'd255, 8'h00);
        send_item(CMD_CLEAR, 8'hFF, 8'hFF);
        send_item(CMD_PUT_BYTE, 8'h00, 8'h11);

        write_size(13'd2);
        send_item(CMD_BEGIN_PUT, 8'd255, 8'h00);
        send_item(CMD_BEGIN_PUT, 8'd1, 8'h00);
        send_item(CMD_PUT_BYTE, 8'h00, 8'h80);
        send_item(CMD_BEGIN_PUT, 8'd0, 8'h00);
        send_item(CMD_GET, 8'h00, 8'h00);
        send_item(CMD_BEGIN_PUT, 8'd0, 8'h00);
        send_item(CMD_GET, 8'h00, 8'h00);

        sizes = '{13'd2, 13'd0, 13'd1, 13'd3, 13'd17, 13'd300, 13'd4096,
                  13'd8191, 13'd4097, 13'd64, 13'($urandom_range(2, 4096))};
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_size(sizes[p]);
            no_idle = (p % 4 == 3);
            run_phase(PHASE_ITEMS);
        end

        idle_drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/lprf_pkg.sv
rtl/core/lprf_ctrl.sv
rtl/core/lprf_dpath.sv
rtl/core/length_prefixed_record_fifo.sv
tb/tb.sv
